// File: sv/qpr_pkg.sv
package qpr_pkg;

  localparam int QW = 16;     // quaternion component width, Q2.14
  localparam int PW = 32;     // point coordinate width, Q16.16
  localparam int PROD_W = 32; // product of two quaternion components
  localparam int MW = 33;     // rotation matrix coefficient
  localparam int N2W = 33;    // squared norm, unsigned
  localparam int XPW = 65;    // coefficient times coordinate
  localparam int ACCW = 67;   // row sum of the numerator
  localparam int QUOW = 33;   // quotient bits produced by the divider

  localparam int FRONT_LAT = 4;             // coefficient and transform stages
  localparam int DIV_LAT = QUOW + 2;        // prepare, one stage per bit, saturate
  localparam int LAT = FRONT_LAT + DIV_LAT;

  typedef logic signed [MW-1:0] coef_t;
  typedef logic signed [PW-1:0] coord_t;
  typedef logic [N2W-1:0] norm_t;
  typedef logic signed [ACCW-1:0] acc_t;

  localparam coord_t SAT_POS = 32'sh7FFF_FFFF;
  localparam coord_t SAT_NEG = 32'sh8000_0000;

endpackage

// File: sv/qpr_coef.sv
module qpr_coef (
  input  logic                                   clk,
  input  logic                                   ld,
  input  logic                                   en,
  input  logic signed [qpr_pkg::QW-1:0]          quat_r,
  input  logic signed [qpr_pkg::QW-1:0]          quat_x,
  input  logic signed [qpr_pkg::QW-1:0]          quat_y,
  input  logic signed [qpr_pkg::QW-1:0]          quat_z,
  input  qpr_pkg::coord_t                        point_x,
  input  qpr_pkg::coord_t                        point_y,
  input  qpr_pkg::coord_t                        point_z,
  output qpr_pkg::coef_t                         m [3][3],
  output qpr_pkg::norm_t                         n2,
  output qpr_pkg::coord_t                        p [3]
);
  import qpr_pkg::*;

  logic signed [PROD_W-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  coord_t p1 [3];

  // First stage: the ten distinct products of quaternion components.
  always_ff @(posedge clk) begin
    if (ld) begin
      ww <= PROD_W'(quat_r * quat_r);
      xx <= PROD_W'(quat_x * quat_x);
      yy <= PROD_W'(quat_y * quat_y);
      zz <= PROD_W'(quat_z * quat_z);
      xy <= PROD_W'(quat_x * quat_y);
      wz <= PROD_W'(quat_r * quat_z);
      xz <= PROD_W'(quat_x * quat_z);
      wy <= PROD_W'(quat_r * quat_y);
      yz <= PROD_W'(quat_y * quat_z);
      wx <= PROD_W'(quat_r * quat_x);
      p1[0] <= point_x;
      p1[1] <= point_y;
      p1[2] <= point_z;
    end
  end

  // Second stage: the matrix. Off-diagonal entries are kept at half value;
  // the doubling happens in the row sum.
  always_ff @(posedge clk) begin
    if (en) begin
      m[0][0] <= MW'(ww) + MW'(xx) - MW'(yy) - MW'(zz);
      m[1][1] <= MW'(ww) - MW'(xx) + MW'(yy) - MW'(zz);
      m[2][2] <= MW'(ww) - MW'(xx) - MW'(yy) + MW'(zz);
      m[0][1] <= MW'(xy) - MW'(wz);
      m[0][2] <= MW'(xz) + MW'(wy);
      m[1][0] <= MW'(xy) + MW'(wz);
      m[1][2] <= MW'(yz) - MW'(wx);
      m[2][0] <= MW'(xz) - MW'(wy);
      m[2][1] <= MW'(yz) + MW'(wx);
      n2 <= norm_t'($unsigned(MW'(ww) + MW'(xx) + MW'(yy) + MW'(zz)));
      p <= p1;
    end
  end

endmodule

// File: sv/qpr_xform.sv
module qpr_xform (
  input  logic           clk,
  input  logic           en,
  input  qpr_pkg::coef_t  m [3][3],
  input  qpr_pkg::norm_t  n2_in,
  input  qpr_pkg::coord_t p [3],
  output qpr_pkg::acc_t   acc [3],
  output qpr_pkg::norm_t  n2_out
);
  import qpr_pkg::*;

  logic signed [XPW-1:0] prod [3][3];
  norm_t n2_d;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= XPW'(m[i][j]) * XPW'(p[j]);
        end
      end
      n2_d <= n2_in;
    end
  end

  // The diagonal term counts once, the halved off-diagonal terms twice.
  always_ff @(posedge clk) begin
    if (en) begin
      acc[0] <= ACCW'(prod[0][0]) + (ACCW'(prod[0][1]) <<< 1) + (ACCW'(prod[0][2]) <<< 1);
      acc[1] <= ACCW'(prod[1][1]) + (ACCW'(prod[1][0]) <<< 1) + (ACCW'(prod[1][2]) <<< 1);
      acc[2] <= ACCW'(prod[2][2]) + (ACCW'(prod[2][0]) <<< 1) + (ACCW'(prod[2][1]) <<< 1);
      n2_out <= n2_d;
    end
  end

endmodule

// File: sv/qpr_div.sv
module qpr_div (
  input  logic            clk,
  input  logic            en,
  input  qpr_pkg::acc_t   num,
  input  qpr_pkg::norm_t  den,
  output qpr_pkg::coord_t quo,
  output logic            clip
);
  import qpr_pkg::*;

  logic [ACCW-1:0] mag;
  logic [ACCW-QUOW-1:0] top_bits;

  logic [N2W-1:0]  rem_s [QUOW+1];
  logic [QUOW-1:0] low_s [QUOW+1];
  logic [QUOW-1:0] q_s   [QUOW+1];
  norm_t           den_s [QUOW+1];
  logic            neg_s [QUOW+1];
  logic            ovf_s [QUOW+1];

  assign mag = num[ACCW-1] ? ACCW'(-num) : ACCW'(num);
  assign top_bits = mag[ACCW-1:QUOW];

  // Preparation: magnitude, and an early overflow test so that only the
  // low quotient bits need a stage each.
  always_ff @(posedge clk) begin
    if (en) begin
      neg_s[0] <= num[ACCW-1];
      ovf_s[0] <= top_bits >= (ACCW-QUOW)'(den);
      rem_s[0] <= (top_bits >= (ACCW-QUOW)'(den)) ? '0 : N2W'(top_bits);
      low_s[0] <= mag[QUOW-1:0];
      q_s[0] <= '0;
      den_s[0] <= den;
    end
  end

  for (genvar k = 0; k < QUOW; k++) begin : g_bit
    logic [N2W:0] trial;
    logic         ge;
    assign trial = {rem_s[k], low_s[k][QUOW-1]};
    assign ge = trial >= {1'b0, den_s[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= ge ? N2W'(trial - {1'b0, den_s[k]}) : N2W'(trial);
        low_s[k+1] <= {low_s[k][QUOW-2:0], 1'b0};
        q_s[k+1] <= {q_s[k][QUOW-2:0], ge};
        den_s[k+1] <= den_s[k];
        neg_s[k+1] <= neg_s[k];
        ovf_s[k+1] <= ovf_s[k];
      end
    end
  end

  logic [QUOW-1:0] qf;
  assign qf = q_s[QUOW];

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_s[QUOW]) begin
        if (ovf_s[QUOW] || qf > QUOW'(33'h0_8000_0000)) begin
          quo <= SAT_NEG;
          clip <= 1'b1;
        end else begin
          quo <= coord_t'(-qf[PW-1:0]);
          clip <= 1'b0;
        end
      end else begin
        if (ovf_s[QUOW] || qf[QUOW-1] || qf[PW-1]) begin
          quo <= SAT_POS;
          clip <= 1'b1;
        end else begin
          quo <= coord_t'(qf[PW-1:0]);
          clip <= 1'b0;
        end
      end
    end
  end

endmodule

// File: sv/quaternion_point_rotate_unit.sv
// Throughput: one request per cycle unless the output stalls; the 33 quotient
// stages of the divider (one quotient bit per stage) set the depth, not the rate.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// A downstream stall freezes the whole pipeline, but an empty first stage still takes a request.
module quaternion_point_rotate_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [qpr_pkg::QW-1:0] quat_r,
  input  logic signed [qpr_pkg::QW-1:0] quat_x,
  input  logic signed [qpr_pkg::QW-1:0] quat_y,
  input  logic signed [qpr_pkg::QW-1:0] quat_z,
  input  qpr_pkg::coord_t               point_x,
  input  qpr_pkg::coord_t               point_y,
  input  qpr_pkg::coord_t               point_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qpr_pkg::coord_t               rotated_x,
  output qpr_pkg::coord_t               rotated_y,
  output qpr_pkg::coord_t               rotated_z,
  output logic                          zero_norm,
  output logic                          clipped
);
  import qpr_pkg::*;

  // One valid bit per pipeline stage. The last one belongs to the output
  // registers inside the dividers.
  logic [LAT-1:0] vld;
  logic [LAT-1:0] zero_d;
  logic           en;

  // The whole pipeline moves together unless the finished result is held.
  assign en = !vld[LAT-1] || out_ready;
  // The first stage may also fill a bubble while the rest is stalled.
  assign in_ready = en || !vld[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (in_ready) begin
        vld[0] <= in_valid;
      end
      if (en) begin
        vld[LAT-1:1] <= vld[LAT-2:0];
      end
    end
  end

  // An all-zero quaternion is the only case with zero norm; the flag rides
  // alongside the data and forces the result at the output.
  always_ff @(posedge clk) begin
    if (in_ready) begin
      zero_d[0] <= (quat_r == '0) && (quat_x == '0) && (quat_y == '0) && (quat_z == '0);
    end
    if (en) begin
      zero_d[LAT-1:1] <= zero_d[LAT-2:0];
    end
  end

  coef_t  m [3][3];
  norm_t  n2;
  coord_t p [3];
  acc_t   acc [3];
  norm_t  n2_x;
  coord_t quo [3];
  logic   clip [3];

  qpr_coef u_coef (
    .clk     (clk),
    .ld      (in_ready),
    .en      (en),
    .quat_r  (quat_r),
    .quat_x  (quat_x),
    .quat_y  (quat_y),
    .quat_z  (quat_z),
    .point_x (point_x),
    .point_y (point_y),
    .point_z (point_z),
    .m       (m),
    .n2      (n2),
    .p       (p)
  );

  qpr_xform u_xform (
    .clk    (clk),
    .en     (en),
    .m      (m),
    .n2_in  (n2),
    .p      (p),
    .acc    (acc),
    .n2_out (n2_x)
  );

  // Three dividers in parallel, one per coordinate, sharing the divisor.
  for (genvar i = 0; i < 3; i++) begin : g_div
    qpr_div u_div (
      .clk  (clk),
      .en   (en),
      .num  (acc[i]),
      .den  (n2_x),
      .quo  (quo[i]),
      .clip (clip[i])
    );
  end

  assign out_valid = vld[LAT-1];
  assign zero_norm = zero_d[LAT-1];
  assign rotated_x = zero_norm ? '0 : quo[0];
  assign rotated_y = zero_norm ? '0 : quo[1];
  assign rotated_z = zero_norm ? '0 : quo[2];
  assign clipped = !zero_norm && (clip[0] || clip[1] || clip[2]);

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the output was free");

  a_clip_excludes_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_norm |-> !clipped && rotated_x == '0 && rotated_y == '0)
    else $error("zero-norm result carries data or a clip flag");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result presented right after reset");

  a_first_stage_held: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !in_ready |=> vld[0])
    else $error("first stage lost a request during a stall");

endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qpr_pkg::*;

  // Result of rotating one point, laid out like the block's result ports.
  typedef struct {
    coord_t rx;
    coord_t ry;
    coord_t rz;
    logic   zn;
    logic   clip;
  } rotation_t;

  // The run is aborted when it takes far longer than the slowest legal run:
  // every request waiting out a long sender gap plus a long receiver stall.
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 1950;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [QW-1:0] quat_r, quat_x, quat_y, quat_z;
  coord_t point_x, point_y, point_z;
  logic out_valid;
  logic out_ready;
  coord_t rotated_x, rotated_y, rotated_z;
  logic zero_norm;
  logic clipped;

  // Expected rotations, oldest first, in the order their requests were accepted.
  rotation_t pending_rotations[$];
  int errors = 0;
  int cycles = 0;
  // When set, the sender issues requests back to back with no gaps.
  bit no_gaps = 0;

  quaternion_point_rotate_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .quat_r    (quat_r),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y),
    .rotated_z (rotated_z),
    .zero_norm (zero_norm),
    .clipped   (clipped)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Rotates p by q as q*(0,p)*conj(q)/|q|^2. The numerator is kept exact in
  // 128 bits, the division truncates toward zero, and each coordinate is then
  // saturated to 32 signed bits. An all-zero quaternion gives a zero point.
  function automatic rotation_t rotate_point(logic signed [QW-1:0] r, x, y, z,
                                              coord_t px, coord_t py, coord_t pz);
    longint w, a, b, c, n2;
    longint m[3][3];
    longint pv[3];
    logic signed [127:0] acc, quo;
    coord_t res[3];
    rotation_t rot;
    w = r;
    a = x;
    b = y;
    c = z;
    pv[0] = px;
    pv[1] = py;
    pv[2] = pz;
    rot.clip = 1'b0;
    n2 = w*w + a*a + b*b + c*c;
    if (n2 == 0) begin
      rot.rx = '0;
      rot.ry = '0;
      rot.rz = '0;
      rot.zn = 1'b1;
      return rot;
    end
    m[0][0] = w*w + a*a - b*b - c*c;
    m[0][1] = 2 * (a*b - w*c);
    m[0][2] = 2 * (a*c + w*b);
    m[1][0] = 2 * (a*b + w*c);
    m[1][1] = w*w - a*a + b*b - c*c;
    m[1][2] = 2 * (b*c - w*a);
    m[2][0] = 2 * (a*c - w*b);
    m[2][1] = 2 * (b*c + w*a);
    m[2][2] = w*w - a*a - b*b + c*c;
    for (int i = 0; i < 3; i++) begin
      acc = '0;
      for (int j = 0; j < 3; j++)
        acc = acc + $signed(128'(m[i][j])) * $signed(128'(pv[j]));
      // Signed division in SystemVerilog truncates toward zero.
      quo = acc / $signed(128'(n2));
      if (quo > $signed(128'(SAT_POS))) begin
        res[i] = SAT_POS;
        rot.clip = 1'b1;
      end else if (quo < $signed(128'(SAT_NEG))) begin
        res[i] = SAT_NEG;
        rot.clip = 1'b1;
      end else begin
        res[i] = coord_t'(quo);
      end
    end
    rot.rx = res[0];
    rot.ry = res[1];
    rot.rz = res[2];
    rot.zn = 1'b0;
    return rot;
  endfunction

  // Mostly short gaps, sometimes a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one request from the falling edge on, holds it until it is taken,
  // records its expected rotation and then leaves a random gap unless no_gaps is set.
  task automatic send_request(logic signed [QW-1:0] r, x, y, z,
                              coord_t px, coord_t py, coord_t pz);
    int gap;
    @(negedge clk);
    quat_r   = r;
    quat_x   = x;
    quat_y   = y;
    quat_z   = z;
    point_x  = px;
    point_y  = py;
    point_z  = pz;
    in_valid = 1'b1;
    // Values read right after the edge are the ones the block saw at it.
    do @(posedge clk); while (!in_ready);
    pending_rotations.push_back(rotate_point(r, x, y, z, px, py, pz));
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_drain();
    while (pending_rotations.size() != 0) @(posedge clk);
  endtask

  // Corner cases: identity, the zero quaternion, the most negative and most
  // positive components, a non-unit quaternion and rotations that saturate.
  task automatic test_directed();
    send_request(16'sd16384, 0, 0, 0, 32'sd65536, -32'sd65536, 32'sd12345);
    send_request(0, 0, 0, 0, SAT_POS, SAT_NEG, 32'sd777);
    send_request(0, 0, 0, 0, 0, 0, 0);
    send_request(16'sd16384, 0, 0, 0, SAT_POS, SAT_NEG, SAT_POS);
    send_request(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                 SAT_NEG, SAT_NEG, SAT_NEG);
    send_request(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                 SAT_POS, SAT_POS, SAT_POS);
    send_request(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                 SAT_POS, SAT_NEG, SAT_POS);
    send_request(16'sd1, 0, 0, 0, 32'sd5, -32'sd5, 32'sd1);
    send_request(0, 16'sd1, 0, 0, 32'sd100, 32'sd200, -32'sd300);
    send_request(0, 0, 16'sd1, 0, 32'sd100, 32'sd200, -32'sd300);
    send_request(0, 0, 0, -16'sd1, 32'sd100, 32'sd200, -32'sd300);
    // Non-unit quaternion with a remainder, so truncation toward zero shows.
    send_request(16'sd3, 16'sd1, 16'sd2, 16'sd5, -32'sd1000003, 32'sd999, 32'sd7);
    // Quarter turn about z, with and without a shrunken quaternion.
    send_request(16'sd11585, 0, 0, 16'sd11585, 32'sd65536, 0, 0);
    send_request(16'sd7, 0, 0, 16'sd7, -32'sd65537, 32'sd3, 32'sd9);
    // An eighth turn about z or x takes a long diagonal point past full scale.
    send_request(16'sd15137, 0, 0, 16'sd6270, SAT_POS, SAT_POS, 0);
    send_request(16'sd15137, 0, 0, 16'sd6270, SAT_NEG, SAT_NEG, 0);
    send_request(16'sd15137, 0, 0, -16'sd6270, SAT_POS, SAT_NEG, SAT_POS);
    send_request(16'sd15137, 16'sd6270, 0, 0, 0, SAT_NEG, SAT_NEG);
    // A half turn about x maps the most negative coordinate past full scale.
    send_request(0, 16'sd16384, 0, 0, 0, SAT_NEG, SAT_NEG);
    send_request(0, 16'sd16384, 0, 0, 32'sd1, SAT_POS, SAT_POS);
  endtask

  // Random requests: mostly near-unit quaternions, which reach the useful
  // range of results, mixed with raw random components, tiny and zero quaternions.
  task automatic test_random(int count);
    logic signed [QW-1:0] r, x, y, z;
    coord_t px, py, pz;
    int kind;
    for (int n = 0; n < count; n++) begin
      if (n % 300 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        r = 16'($urandom_range(0, 16384));
        if ($urandom_range(0, 1) == 1) r = -r;
        x = 16'($urandom_range(0, 9000)) - 16'sd4500;
        y = 16'($urandom_range(0, 9000)) - 16'sd4500;
        z = 16'($urandom_range(0, 9000)) - 16'sd4500;
      end else if (kind < 8) begin
        r = 16'($urandom);
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
      end else if (kind < 9) begin
        r = 16'($urandom_range(0, 6)) - 16'sd3;
        x = 16'($urandom_range(0, 6)) - 16'sd3;
        y = 16'($urandom_range(0, 6)) - 16'sd3;
        z = 16'($urandom_range(0, 6)) - 16'sd3;
      end else begin
        r = '0;
        x = '0;
        y = '0;
        z = '0;
      end
      if ($urandom_range(0, 2) == 0) begin
        px = 32'($urandom_range(0, 2000000)) - 32'sd1000000;
        py = 32'($urandom_range(0, 2000000)) - 32'sd1000000;
        pz = 32'($urandom_range(0, 2000000)) - 32'sd1000000;
      end else begin
        px = $urandom;
        py = $urandom;
        pz = $urandom;
      end
      send_request(r, x, y, z, px, py, pz);
    end
    no_gaps = 0;
  endtask

  // The sender holds off until the pipeline is empty, then resumes.
  task automatic test_drain_pause();
    for (int n = 0; n < 10; n++)
      send_request(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   $urandom, $urandom, $urandom);
    @(negedge clk);
    in_valid = 1'b0;
    wait_for_drain();
    for (int n = 0; n < 10; n++)
      send_request(16'sd16384, 0, 0, 0, $urandom, $urandom, $urandom);
  endtask

  // The receiver stalls in bursts: long runs of ready, short and long stalls.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0:       out_ready <= 1'b0;
        1, 2:    out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0) ? 1'b1 : out_ready;
      endcase
    end
  end

  // Compares each taken result with the oldest expected rotation.
  always @(posedge clk) begin
    rotation_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_rotations.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = pending_rotations.pop_front();
        if (rotated_x !== want.rx) begin
          $error("rotated_x: expected %0d, got %0d", want.rx, rotated_x);
          errors++;
        end
        if (rotated_y !== want.ry) begin
          $error("rotated_y: expected %0d, got %0d", want.ry, rotated_y);
          errors++;
        end
        if (rotated_z !== want.rz) begin
          $error("rotated_z: expected %0d, got %0d", want.rz, rotated_z);
          errors++;
        end
        if (zero_norm !== want.zn) begin
          $error("zero_norm: expected %0b, got %0b", want.zn, zero_norm);
          errors++;
        end
        if (clipped !== want.clip) begin
          $error("clipped: expected %0b, got %0b", want.clip, clipped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    quat_r   = '0;
    quat_x   = '0;
    quat_y   = '0;
    quat_z   = '0;
    point_x  = '0;
    point_y  = '0;
    point_z  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_drain_pause();
    test_random(RANDOM_ITEMS);

    @(negedge clk);
    in_valid = 1'b0;
    wait_for_drain();
    // Let any stray result show up after the last expected one.
    repeat (LAT + 20) @(posedge clk);
    if (errors == 0 && pending_rotations.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: quaternion_point_rotate_unit.f
sv/qpr_pkg.sv
sv/qpr_coef.sv
sv/qpr_xform.sv
sv/qpr_div.sv
sv/quaternion_point_rotate_unit.sv
sim/tb.sv
